### sv/fp32_adder_flush_to_zero_macros.svh
// Assertion macros for the checker module of the fp32 adder.
// Depends on nothing; included by the checker module.
`ifndef FP32_ADDER_FLUSH_TO_ZERO_MACROS_SVH
`define FP32_ADDER_FLUSH_TO_ZERO_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fpa_pkg.sv
// Package for the fp32 adder: field widths, special encodings and alignment constants.
// No dependencies.
package fpa_pkg;
    localparam int unsigned ExpW = 8;
    localparam int unsigned FracW = 23;
    localparam logic [7:0] ExpMax = 8'd255;
    localparam logic [31:0] QNaN = 32'h7FFF_FFFF;
    localparam int unsigned FarDiff = 25;
    localparam int unsigned TopPos = 26;
endpackage

### sv/fp32_adder_flush_to_zero.sv
// Top level of the fp32 adder: input register, adder logic, output register.
// Depends on fpa_pkg and fpa_core.
//
// Usage: a request carries operand_a and operand_b (binary32 bit patterns) on
// in_valid; it is taken at a clock edge with in_valid high and in_stall low.
// The sum leaves on out_valid/sum_bits and is taken when out_stall is low.
// The request is held in the operand register and its sum is then registered in
// the result register, which drives out_valid; one request is taken every cycle
// while the output is not stalled. The add is one combinational pass between the
// operand register and the result register.
// When the receiver stalls, the result register holds and the operand stage
// fills; in_stall rises only when both are full, so no request is lost.
// Reset clears the valid flags; no result is shown until a request arrives.
// Subnormals are flushed to zero and NaNs become 0x7FFFFFFF.
module fp32_adder_flush_to_zero (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sum_bits
);
    import fpa_pkg::*;

    logic        a_valid_reg;
    logic [31:0] a_reg, b_reg;
    logic        o_valid_reg;
    logic [31:0] o_reg;
    logic [31:0] sum_next;
    logic        adv;

    fpa_core u_core (.a(a_reg), .b(b_reg), .sum(sum_next));

    assign adv = !o_valid_reg || !out_stall;
    assign in_stall = a_valid_reg && !adv;
    assign out_valid = o_valid_reg;
    assign sum_bits = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                o_valid_reg <= a_valid_reg;
            end
            if (!in_stall)
            begin
                a_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid_reg)
        begin
            o_reg <= sum_next;
        end
        if (!in_stall && in_valid)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
    end
endmodule

### sv/fpa_core.sv
// Combinational single-precision add with flush to zero and nearest-even rounding.
// Depends on fpa_pkg.
module fpa_core (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);
    import fpa_pkg::*;

    logic        sa, sb, bs;
    logic [7:0]  ea, eb, be, se, diff;
    logic [22:0] fa, fb;
    logic [31:0] big, sml;
    logic [26:0] bm, sm, sub_t, norm;
    logic [23:0] sm24;
    logic [27:0] addv;
    logic [26:0] addn;
    logic [4:0]  lz;
    logic [8:0]  e_add, e_sub;
    logic        add_path, equal_mag, st;
    logic [7:0]  sh;

    function automatic logic [31:0] finish(input logic s, input logic [8:0] e,
                                           input logic [26:0] m);
        logic [24:0] r;
        logic [8:0]  ee;
        r = {1'b0, m[26:3]};
        if (m[2] && (m[1:0] != 2'b00 || m[3]))
        begin
            r = r + 25'd1;
        end
        ee = e;
        if (r[24])
        begin
            ee = e + 9'd1;
            r = '0;
        end
        if (ee >= {1'b0, ExpMax})
        begin
            finish = {s, ExpMax, 23'd0};
        end
        else
        begin
            finish = {s, ee[7:0], r[22:0]};
        end
    endfunction

    always_comb
    begin
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        st = 1'b0;
        equal_mag = a[30:0] == b[30:0];
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        be = big[30:23];
        se = sml[30:23];
        bs = big[31];
        diff = be - se;
        bm = {1'b1, big[22:0], 3'b000};
        sm24 = {1'b1, sml[22:0]};
        sh = diff - 8'd2;
        if (diff < 8'd4)
        begin
            sm = {3'b000, sm24} << (3 - diff[1:0]);
        end
        else
        begin
            st = (sm24 & ((24'd1 << sh[4:0]) - 24'd1)) != 24'd0;
            sm = {2'b00, (sm24 >> sh[4:0]), st};
        end
        if (diff >= 8'd4 && sh >= 8'd24)
        begin
            sm = {26'd0, 1'b1};
        end
        add_path = sa == sb;
        addv = {1'b0, bm} + {1'b0, sm};
        e_add = {1'b0, be};
        addn = addv[26:0];
        if (addv[27])
        begin
            // Drop one bit and fold the two lowest bits into the sticky bit.
            addn = {addv[27:2], addv[1:0] != 2'b00};
            e_add = e_add + 9'd1;
        end
        sub_t = bm - sm;
        lz = 5'd26;
        for (int i = 26; i >= 0; i--)
        begin
            if (sub_t[i] && lz == 5'd26)
            begin
                lz = 5'(26 - i);
            end
        end
        norm = sub_t << lz;
        e_sub = {1'b0, be} - {4'd0, lz};

        if ((ea == ExpMax && fa != '0) || (eb == ExpMax && fb != '0))
            sum = QNaN;
        else if (ea == ExpMax && eb == ExpMax)
            sum = (sa != sb) ? QNaN : {sa, ExpMax, 23'd0};
        else if (ea == ExpMax)
            sum = {sa, ExpMax, 23'd0};
        else if (eb == ExpMax)
            sum = {sb, ExpMax, 23'd0};
        else if (ea == 8'd0)
            sum = (eb == 8'd0) ? {sa & sb, 31'd0} : b;
        else if (eb == 8'd0)
            sum = a;
        else if (diff > 8'(FarDiff))
            sum = big;
        else if (add_path)
            sum = finish(bs, e_add, addn);
        else if (equal_mag || {1'b0, be} <= {4'd0, lz})
            sum = 32'd0;
        else
            sum = finish(bs, e_sub, norm);
    end
endmodule

### sv/fpa_checker.sv
// Port-level checker for the fp32 adder, bound to the top level.
// Depends on the macros header.
`include "fp32_adder_flush_to_zero_macros.svh"
module fpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sum_bits
);
    `FPA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(sum_bits), "stalled result changed")
    `FPA_ASSERT_IMPL(a_nostall_empty, clk, rst_n, !out_valid, !in_stall,
        "input stalled with empty output")
    `FPA_ASSERT_NEXT(a_req_hold, clk, rst_n, in_valid && in_stall, in_valid,
        "stalled request withdrawn")
    `FPA_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall,
        "input stalled without output stall")
endmodule

bind fp32_adder_flush_to_zero fpa_checker u_fpa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
);
